[hw/rtl/mfr_pkg.sv]
// Package for the marker delimited frame receiver.
// Holds opcodes, register indexes, reset values and shared structs.
// No dependencies.
`default_nettype none

package mfr_pkg;

  localparam int unsigned BufferDepth = 128;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 7;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] StartMarkerRst = 8'd64;  // '@'
  localparam logic [ByteW-1:0] EndMarkerRst   = 8'd42;  // '*'
  localparam logic [ByteW-1:0] Terminator     = 8'd0;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_POLL = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_MARKER = 2'd0,
    REG_END_MARKER   = 2'd1
  } reg_e;

  // Per item status handed from the frame control to the result register.
  typedef struct packed {
    logic              frame_ready;
    logic [IndexW-1:0] frame_length;
    logic              overflow;
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/mfr_buf.sv]
// Frame buffer memory: one write port, one read port with registered data.
// Depends on mfr_pkg for its default depth.
`default_nettype none

module mfr_buf #(
  parameter int unsigned DEPTH = mfr_pkg::BufferDepth,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [7:0]    rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[hw/rtl/mfr_ctrl.sv]
// Frame control: marker detection, write index, ready and overflow flags.
// Depends on mfr_pkg.
`default_nettype none

module mfr_ctrl #(
  parameter int unsigned DEPTH = mfr_pkg::BufferDepth,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [1:0]      opcode_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic [7:0]      start_marker_i,
  input  wire logic [7:0]      end_marker_i,
  output logic                 wr_en_o,
  output logic      [AW-1:0]   wr_addr_o,
  output logic      [7:0]      wr_data_o,
  output mfr_pkg::status_t     status_o
);

  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic          receiving_q, receiving_d;
  logic [AW-1:0] widx_q, widx_d;
  logic          ready_q, ready_d;
  logic          ovf_q, ovf_d;

  always_comb begin
    receiving_d = receiving_q;
    widx_d      = widx_q;
    ready_d     = ready_q;
    ovf_d       = ovf_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = widx_q;
    wr_data_o   = rx_byte_i;
    case (mfr_pkg::op_e'(opcode_i))
      mfr_pkg::OP_BYTE: begin
        if (!receiving_q) begin
          if (rx_byte_i == start_marker_i && !ready_q) begin
            receiving_d = 1'b1;
            widx_d      = '0;
            ovf_d       = 1'b0;
          end
        end else if (rx_byte_i == end_marker_i) begin
          // close: terminator after payload, always fits
          receiving_d = 1'b0;
          ready_d     = 1'b1;
          wr_en_o     = 1'b1;
          wr_data_o   = mfr_pkg::Terminator;
        end else if (widx_q != LastIdx) begin
          wr_en_o = 1'b1;
          widx_d  = widx_q + AW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      mfr_pkg::OP_POLL: begin
        ready_d = 1'b0;
      end
      default: begin
      end
    endcase
    wr_en_o = wr_en_o & step_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      widx_q      <= '0;
      ready_q     <= 1'b0;
      ovf_q       <= 1'b0;
    end else if (step_i) begin
      receiving_q <= receiving_d;
      widx_q      <= widx_d;
      ready_q     <= ready_d;
      ovf_q       <= ovf_d;
    end
  end

  assign status_o.frame_ready  = ready_q;
  assign status_o.frame_length = mfr_pkg::IndexW'(widx_d);
  assign status_o.overflow     = ovf_d;

endmodule

`default_nettype wire

[hw/rtl/marker_delimited_frame_receiver_top.sv]
// Marker delimited frame receiver, top level.
// Depends on mfr_pkg, mfr_ctrl and mfr_buf.
//
// Collects frames from a byte stream: a start marker opens a frame (only
// while no finished frame waits to be polled), payload bytes are stored
// from buffer position 0, and the end marker writes a zero terminator and
// raises the ready flag. Each transfer on the input channel carries one
// operation (byte, poll, read) and yields exactly one transfer on the
// output channel. Throughput is one transfer per cycle while out_ready_i
// does not stall the output; each operation passes through the input
// register and the result register, the buffer read port registering
// its data into the result stage. The markers are written through the
// configuration channel (index 0 start, index 1 end, other indexes
// ignored) and must only change while the block is idle. Reads of buffer
// entries never written return undefined data.
`default_nettype none

module marker_delimited_frame_receiver_top #(
  parameter int unsigned BUFFER_DEPTH = mfr_pkg::BufferDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input transfers
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [6:0]  read_index_i,
  // result transfers
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             frame_ready_o,
  output logic      [7:0]  read_data_o,
  output logic      [6:0]  frame_length_o,
  output logic             overflow_o,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [7:0] start_marker_q;
  logic [7:0] end_marker_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= mfr_pkg::StartMarkerRst;
      end_marker_q   <= mfr_pkg::EndMarkerRst;
    end else if (cfg_valid_i) begin
      case (mfr_pkg::reg_e'(cfg_index_i))
        mfr_pkg::REG_START_MARKER: start_marker_q <= cfg_data_i;
        mfr_pkg::REG_END_MARKER:   end_marker_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: input register feeds the result register; the stage moves
  // on whenever the result register is empty or being drained.
  // ---------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic step;
  logic in_xfer;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // input register (payload, no reset)
  logic [1:0] opcode_q;
  logic [7:0] rx_byte_q;
  logic [6:0] read_index_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      opcode_q     <= opcode_i;
      rx_byte_q    <= rx_byte_i;
      read_index_q <= read_index_i;
    end
  end

  // ---------------------------------------------------------------------
  // Frame control and buffer
  // ---------------------------------------------------------------------
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [7:0]        wr_data;
  mfr_pkg::status_t  status;
  logic              rd_hit;
  logic              rd_en;
  logic [7:0]        rd_data;

  mfr_ctrl #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .opcode_i       (opcode_q),
    .rx_byte_i      (rx_byte_q),
    .start_marker_i (start_marker_q),
    .end_marker_i   (end_marker_q),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .status_o       (status)
  );

  // reads past the buffer end answer zero
  assign rd_hit = (mfr_pkg::op_e'(opcode_q) == mfr_pkg::OP_READ) &&
                  (32'(read_index_q) < 32'(BUFFER_DEPTH));
  assign rd_en  = step && rd_hit;

  mfr_buf #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (AW'(read_index_q)),
    .rd_data_o (rd_data)
  );

  // ---------------------------------------------------------------------
  // Result register; read data arrives from the buffer's own register
  // ---------------------------------------------------------------------
  mfr_pkg::status_t status_q;
  logic             rd_keep_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      status_q  <= status;
      rd_keep_q <= rd_hit;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_ready_o  = status_q.frame_ready;
  assign frame_length_o = status_q.frame_length;
  assign overflow_o     = status_q.overflow;
  assign read_data_o    = {8{rd_keep_q}} & rd_data;

endmodule

`default_nettype wire

[hw/rtl/mfr_checker.sv]
// Port level checker for the marker delimited frame receiver.
// Depends on marker_delimited_frame_receiver_top (bound below).
`default_nettype none

module mfr_checker #(
  parameter int unsigned DEPTH = mfr_pkg::BufferDepth
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       frame_ready_o,
  input wire logic [7:0] read_data_o,
  input wire logic [6:0] frame_length_o,
  input wire logic       overflow_o
);

  localparam logic [6:0] FullLen = 7'(DEPTH - 1);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_ready_o) &&
    $stable(read_data_o) && $stable(frame_length_o) && $stable(overflow_o))
    else $error("result changed while stalled");

  // overflow only once the buffer holds its maximum payload
  a_ovf_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> frame_length_o == FullLen)
    else $error("overflow with buffer not full");

  // an empty result stage never blocks the input
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result stage");

  // a result being drained frees the input in the same cycle
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input stalled while result drains");

endmodule

bind marker_delimited_frame_receiver_top mfr_checker #(
  .DEPTH (BUFFER_DEPTH)
) u_mfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .frame_ready_o  (frame_ready_o),
  .read_data_o    (read_data_o),
  .frame_length_o (frame_length_o),
  .overflow_o     (overflow_o)
);

`default_nettype wire
